@@ design/sgew_pkg.sv @@
`timescale 1ns / 1ps

package sgew_pkg;

  // Field and datapath widths.
  localparam int GAIN_IN_W   = 22;
  localparam int EXPO_W      = 16;
  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int GAIN_W      = 18;
  localparam int LVL_W       = 14;
  localparam int ROW_W       = 5;
  localparam int NUM_W       = 20;
  localparam int DIG_W       = 14;
  localparam int UNIT_W      = 15;
  localparam int DIV_STEPS   = NUM_W;
  localparam int CNT_W       = $clog2(DIV_STEPS);

  // Table sizes.
  localparam int ROM_ROWS         = 29;
  localparam int GAIN_LEVELS_DEF  = 29;

  // Gain saturation limits (Q10).
  localparam logic [GAIN_IN_W-1:0] GAIN_MIN = 22'd1024;
  localparam logic [GAIN_IN_W-1:0] GAIN_MAX = 22'd131072;

  // Sensor register addresses.
  localparam logic [ADDR_W-1:0] ADDR_EXPO_HI = 16'h0d03;
  localparam logic [ADDR_W-1:0] ADDR_EXPO_LO = 16'h0d04;
  localparam logic [ADDR_W-1:0] ADDR_ANA0    = 16'h00d1;
  localparam logic [ADDR_W-1:0] ADDR_ANA1    = 16'h00d0;
  localparam logic [ADDR_W-1:0] ADDR_BANK    = 16'h031d;
  localparam logic [ADDR_W-1:0] ADDR_ANA2    = 16'h0dc1;
  localparam logic [ADDR_W-1:0] ADDR_ANA3    = 16'h0155;
  localparam logic [ADDR_W-1:0] ADDR_ANA4    = 16'h00b8;
  localparam logic [ADDR_W-1:0] ADDR_ANA5    = 16'h00b9;
  localparam logic [ADDR_W-1:0] ADDR_DIG_HI  = 16'h00b1;
  localparam logic [ADDR_W-1:0] ADDR_DIG_LO  = 16'h00b2;

  // Fixed data bytes for the bank select writes.
  localparam logic [DATA_W-1:0] BANK_OPEN  = 8'h2e;
  localparam logic [DATA_W-1:0] BANK_CLOSE = 8'h28;

  // Order of the register writes of one update.
  typedef enum logic [3:0] {
    STEP_EXPO_HI,
    STEP_EXPO_LO,
    STEP_ANA0,
    STEP_ANA1,
    STEP_BANK_OPEN,
    STEP_ANA2,
    STEP_BANK_CLOSE,
    STEP_ANA3,
    STEP_ANA4,
    STEP_ANA5,
    STEP_DIG_HI,
    STEP_DIG_LO
  } step_t;

  // Channel payloads.
  typedef struct packed {
    logic [GAIN_IN_W-1:0] gain_q10;
    logic [EXPO_W-1:0]    exposure_lines;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] reg_addr;
    logic [DATA_W-1:0] reg_data;
    logic              last;
  } out_t;

  // Operands that the write formatter draws its data from.
  typedef struct packed {
    step_t             step;
    logic [EXPO_W-1:0] expo;
    logic [ROW_W-1:0]  row;
    logic [DIG_W-1:0]  dig;
  } wr_src_t;

  // Result of the shared subtractor.
  typedef struct packed {
    logic [UNIT_W-1:0] diff;
    logic              ge;
  } sub_res_t;

  // Ascending analog gain levels, 64 is unity.
  function automatic logic [LVL_W-1:0] level_at(input logic [ROW_W-1:0] r);
    logic [LVL_W-1:0] v;
    case (r)
      5'd0:    v = 14'd64;
      5'd1:    v = 14'd76;
      5'd2:    v = 14'd90;
      5'd3:    v = 14'd106;
      5'd4:    v = 14'd128;
      5'd5:    v = 14'd152;
      5'd6:    v = 14'd179;
      5'd7:    v = 14'd212;
      5'd8:    v = 14'd256;
      5'd9:    v = 14'd303;
      5'd10:   v = 14'd358;
      5'd11:   v = 14'd425;
      5'd12:   v = 14'd512;
      5'd13:   v = 14'd607;
      5'd14:   v = 14'd716;
      5'd15:   v = 14'd848;
      5'd16:   v = 14'd1024;
      5'd17:   v = 14'd1214;
      5'd18:   v = 14'd1434;
      5'd19:   v = 14'd1699;
      5'd20:   v = 14'd2048;
      5'd21:   v = 14'd2427;
      5'd22:   v = 14'd2865;
      5'd23:   v = 14'd3393;
      5'd24:   v = 14'd4096;
      5'd25:   v = 14'd4855;
      5'd26:   v = 14'd5730;
      5'd27:   v = 14'd6809;
      5'd28:   v = 14'd8192;
      default: v = 14'd8192;
    endcase
    return v;
  endfunction

  // Analog setting row; the first byte sits in the top bits.
  function automatic logic [6*DATA_W-1:0] setting_row(input logic [ROW_W-1:0] r);
    logic [6*DATA_W-1:0] v;
    case (r)
      5'd0:    v = 48'h00_00_00_80_01_00;
      5'd1:    v = 48'h0a_00_00_80_01_0b;
      5'd2:    v = 48'h00_01_00_80_01_19;
      5'd3:    v = 48'h0a_01_00_80_01_2a;
      5'd4:    v = 48'h00_02_00_80_02_00;
      5'd5:    v = 48'h0a_02_00_80_02_17;
      5'd6:    v = 48'h00_03_00_80_02_33;
      5'd7:    v = 48'h0a_03_00_80_03_14;
      5'd8:    v = 48'h00_04_00_90_04_00;
      5'd9:    v = 48'h0a_04_00_90_04_2f;
      5'd10:   v = 48'h00_05_00_90_05_26;
      5'd11:   v = 48'h0a_05_00_90_06_28;
      5'd12:   v = 48'h00_06_00_a0_08_00;
      5'd13:   v = 48'h0a_06_00_a0_09_1e;
      5'd14:   v = 48'h12_46_00_a0_0b_0c;
      5'd15:   v = 48'h19_66_00_a0_0d_10;
      5'd16:   v = 48'h00_04_01_a0_10_00;
      5'd17:   v = 48'h0a_04_01_a0_12_3d;
      5'd18:   v = 48'h00_05_01_b0_16_19;
      5'd19:   v = 48'h0a_05_01_c0_1a_23;
      5'd20:   v = 48'h00_06_01_c0_20_00;
      5'd21:   v = 48'h0a_06_01_c0_25_3b;
      5'd22:   v = 48'h12_46_01_c0_2c_30;
      5'd23:   v = 48'h19_66_01_d0_35_01;
      5'd24:   v = 48'h20_06_01_e0_3f_3f;
      5'd25:   v = 48'h25_06_01_e0_3f_3f;
      5'd26:   v = 48'h29_26_01_e0_3f_3f;
      5'd27:   v = 48'h2c_c6_01_f0_3f_3f;
      5'd28:   v = 48'h30_06_01_f0_3f_3f;
      default: v = 48'h00_00_00_00_00_00;
    endcase
    return v;
  endfunction

endpackage

@@ design/sgew_sub_unit.sv @@
`timescale 1ns / 1ps

module sgew_sub_unit
  import sgew_pkg::*;
(
  input  logic [UNIT_W-1:0] a,
  input  logic [UNIT_W-1:0] b,
  output sub_res_t          res
);

  logic [UNIT_W:0] wide;

  // One subtract serves both the level compare and the divider step.
  // The borrow out says whether a is below b.
  assign wide     = {1'b0, a} - {1'b0, b};
  assign res.diff = wide[UNIT_W-1:0];
  assign res.ge   = ~wide[UNIT_W];

endmodule

@@ design/sgew_write_fmt.sv @@
`timescale 1ns / 1ps

module sgew_write_fmt
  import sgew_pkg::*;
(
  input  wr_src_t           src,
  output logic [ADDR_W-1:0] reg_addr,
  output logic [DATA_W-1:0] reg_data
);

  logic [6*DATA_W-1:0] row_bytes;

  assign row_bytes = setting_row(src.row);

  // Map the current write of the sequence to its address and byte.
  always_comb begin
    case (src.step)
      STEP_EXPO_HI: begin
        reg_addr = ADDR_EXPO_HI;
        reg_data = src.expo[EXPO_W-1:DATA_W];
      end
      STEP_EXPO_LO: begin
        reg_addr = ADDR_EXPO_LO;
        reg_data = src.expo[DATA_W-1:0];
      end
      STEP_ANA0: begin
        reg_addr = ADDR_ANA0;
        reg_data = row_bytes[47:40];
      end
      STEP_ANA1: begin
        reg_addr = ADDR_ANA1;
        reg_data = row_bytes[39:32];
      end
      STEP_BANK_OPEN: begin
        reg_addr = ADDR_BANK;
        reg_data = BANK_OPEN;
      end
      STEP_ANA2: begin
        reg_addr = ADDR_ANA2;
        reg_data = row_bytes[31:24];
      end
      STEP_BANK_CLOSE: begin
        reg_addr = ADDR_BANK;
        reg_data = BANK_CLOSE;
      end
      STEP_ANA3: begin
        reg_addr = ADDR_ANA3;
        reg_data = row_bytes[23:16];
      end
      STEP_ANA4: begin
        reg_addr = ADDR_ANA4;
        reg_data = row_bytes[15:8];
      end
      STEP_ANA5: begin
        reg_addr = ADDR_ANA5;
        reg_data = row_bytes[7:0];
      end
      STEP_DIG_HI: begin
        reg_addr = ADDR_DIG_HI;
        reg_data = src.dig[DIG_W-1:6];
      end
      STEP_DIG_LO: begin
        reg_addr = ADDR_DIG_LO;
        reg_data = {src.dig[5:0], 2'b00};
      end
      default: begin
        reg_addr = '0;
        reg_data = '0;
      end
    endcase
  end

endmodule

@@ design/sensor_gain_exposure_writer.sv @@
`timescale 1ns / 1ps

// Turns one auto-exposure update (Q10 total gain and exposure line count) into
// a run of sensor register writes, one write per output transfer, with last
// set on the final write of the update. A changed exposure gives two writes;
// a changed saturated gain gives ten more. An update that changes the gain is
// accepted, then searched against the first min(GAIN_LEVELS, 29) table levels
// and put through a restoring division of the 20-bit level numerator, both on
// one shared subtractor, then gives one write per cycle while the output side
// keeps up. An update with only an exposure change goes from its accept
// straight to its writes, and one that changes nothing is done in its accept
// cycle. The input is not ready while an update is being worked on; the last
// write may still wait in the output register while the next update is taken.
module sensor_gain_exposure_writer
  import sgew_pkg::*;
#(
  parameter int GAIN_LEVELS = GAIN_LEVELS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int SEARCH_N = (GAIN_LEVELS < ROM_ROWS) ? GAIN_LEVELS : ROM_ROWS;
  localparam int IDX_W    = (SEARCH_N > 1) ? $clog2(SEARCH_N) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic                gain_chg_r, gain_chg_nxt;
  logic                expo_chg_r, expo_chg_nxt;
  logic [EXPO_W-1:0]   expo_r, expo_nxt;
  logic [LVL_W-1:0]    lvl_r, lvl_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [DIG_W-1:0]    rem_r, rem_nxt;
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic [DIG_W-1:0]    quo_r, quo_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  step_t               step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r, out_data_nxt;
  logic [GAIN_W-1:0]   last_gain_r, last_gain_nxt;
  logic [EXPO_W:0]     last_expo_r, last_expo_nxt;

  logic                in_xfer;
  logic [GAIN_W-1:0]   gain_sat;
  logic [UNIT_W-1:0]   unit_a;
  logic [UNIT_W-1:0]   unit_b;
  sub_res_t            unit_res;
  wr_src_t             wr_src;
  logic [ADDR_W-1:0]   wr_addr;
  logic [DATA_W-1:0]   wr_data;
  logic                wr_last;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Saturate the requested gain to the supported range.
  always_comb begin
    if (in_data.gain_q10 < GAIN_MIN) begin
      gain_sat = GAIN_W'(GAIN_MIN);
    end else if (in_data.gain_q10 > GAIN_MAX) begin
      gain_sat = GAIN_W'(GAIN_MAX);
    end else begin
      gain_sat = in_data.gain_q10[GAIN_W-1:0];
    end
  end

  // Operand select for the shared subtractor: level compare or divider step.
  always_comb begin
    if (state_r == ST_SEARCH) begin
      unit_a = UNIT_W'(lvl_r);
      unit_b = UNIT_W'(level_at(ROW_W'(idx_r)));
    end else begin
      unit_a = {rem_r, num_r[NUM_W-1]};
      unit_b = UNIT_W'(level_at(row_r));
    end
  end

  sgew_sub_unit u_sub (
    .a   (unit_a),
    .b   (unit_b),
    .res (unit_res)
  );

  // Write formatter for the current step.
  assign wr_src.step = step_r;
  assign wr_src.expo = expo_r;
  assign wr_src.row  = row_r;
  assign wr_src.dig  = quo_r;

  sgew_write_fmt u_fmt (
    .src      (wr_src),
    .reg_addr (wr_addr),
    .reg_data (wr_data)
  );

  assign wr_last = (step_r == STEP_DIG_LO) || ((step_r == STEP_EXPO_LO) && !gain_chg_r);

  // Sequencer: accept, search the level table and divide on a gain change, then emit the writes.
  always_comb begin
    state_nxt     = state_r;
    gain_chg_nxt  = gain_chg_r;
    expo_chg_nxt  = expo_chg_r;
    expo_nxt      = expo_r;
    lvl_nxt       = lvl_r;
    idx_nxt       = idx_r;
    row_nxt       = row_r;
    rem_nxt       = rem_r;
    num_nxt       = num_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    last_gain_nxt = last_gain_r;
    last_expo_nxt = last_expo_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          expo_nxt      = in_data.exposure_lines;
          lvl_nxt       = gain_sat[GAIN_W-1:4];
          expo_chg_nxt  = ({1'b0, in_data.exposure_lines} != last_expo_r);
          gain_chg_nxt  = (gain_sat != last_gain_r);
          last_expo_nxt = {1'b0, in_data.exposure_lines};
          last_gain_nxt = gain_sat;
          idx_nxt       = '0;
          row_nxt       = '0;
          step_nxt      = STEP_EXPO_HI;
          if (gain_sat != last_gain_r) begin
            state_nxt = ST_SEARCH;
          end else if ({1'b0, in_data.exposure_lines} != last_expo_r) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_SEARCH: begin
        // Keep the highest table level that does not exceed the gain level.
        if (unit_res.ge) begin
          row_nxt = ROW_W'(idx_r);
        end
        if (idx_r == IDX_W'(SEARCH_N - 1)) begin
          state_nxt = ST_DIV;
          cnt_nxt   = '0;
          rem_nxt   = '0;
          quo_nxt   = '0;
          num_nxt   = {lvl_r, 6'b000000};
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DIV: begin
        // One restoring division step per cycle, numerator MSB first.
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
        if (unit_res.ge) begin
          rem_nxt = unit_res.diff[DIG_W-1:0];
          quo_nxt = {quo_r[DIG_W-2:0], 1'b1};
        end else begin
          rem_nxt = unit_a[DIG_W-1:0];
          quo_nxt = {quo_r[DIG_W-2:0], 1'b0};
        end
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_EMIT;
          step_nxt  = expo_chg_r ? STEP_EXPO_HI : STEP_ANA0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_EMIT: begin
        // Load the next write whenever the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.reg_addr = wr_addr;
          out_data_nxt.reg_data = wr_data;
          out_data_nxt.last     = wr_last;
          if (wr_last) begin
            state_nxt = ST_IDLE;
          end else begin
            step_nxt = step_t'(step_r + 1'b1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      last_gain_r <= '1;
      last_expo_r <= '1;
      gain_chg_r  <= 1'b0;
      expo_chg_r  <= 1'b0;
      step_r      <= STEP_EXPO_HI;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_gain_r <= last_gain_nxt;
      last_expo_r <= last_expo_nxt;
      gain_chg_r  <= gain_chg_nxt;
      expo_chg_r  <= expo_chg_nxt;
      step_r      <= step_nxt;
    end
    expo_r     <= expo_nxt;
    lvl_r      <= lvl_nxt;
    idx_r      <= idx_nxt;
    row_r      <= row_nxt;
    rem_r      <= rem_nxt;
    num_r      <= num_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
